// ===== hdl/ecd_pkg.sv =====
`timescale 1ns / 1ps

package ecd_pkg;

   // Field and register types
   typedef logic [31:0] tick_type;
   typedef logic [19:0] rate_type;
   typedef logic [13:0] year_type;
   typedef logic [3:0]  month_type;
   typedef logic [4:0]  day_type;
   typedef logic [4:0]  hour_type;
   typedef logic [5:0]  minute_type;
   typedef logic [5:0]  second_type;
   typedef logic [15:0] days_type;
   typedef logic [2:0]  csr_index_type;
   typedef logic [16:0] day_secs_type;

   // Register indexes
   localparam csr_index_type CSR_TICK_RATE   = 3'd0;
   localparam csr_index_type CSR_START_TICK  = 3'd1;
   localparam csr_index_type CSR_BASE_YEAR   = 3'd2;
   localparam csr_index_type CSR_BASE_MONTH  = 3'd3;
   localparam csr_index_type CSR_BASE_DAY    = 3'd4;
   localparam csr_index_type CSR_BASE_HOUR   = 3'd5;
   localparam csr_index_type CSR_BASE_MINUTE = 3'd6;
   localparam csr_index_type CSR_BASE_SECOND = 3'd7;

   // Register reset values
   localparam rate_type   RST_TICK_RATE   = 20'd1000;
   localparam tick_type   RST_START_TICK  = 32'd0;
   localparam year_type   RST_BASE_YEAR   = 14'd2026;
   localparam month_type  RST_BASE_MONTH  = 4'd8;
   localparam day_type    RST_BASE_DAY    = 5'd26;
   localparam hour_type   RST_BASE_HOUR   = 5'd9;
   localparam minute_type RST_BASE_MINUTE = 6'd0;
   localparam second_type RST_BASE_SECOND = 6'd0;

   // Time constants, as divisors
   localparam rate_type DAY_SECONDS    = 20'd86400;
   localparam rate_type HOUR_SECONDS   = 20'd3600;
   localparam rate_type MINUTE_SECONDS = 20'd60;

   // Calendar constants
   localparam month_type MONTH_FEB      = 4'd2;
   localparam logic [4:0] MONTHS_IN_YEAR = 5'd12;
   localparam day_type   LEAP_FEB_DAYS  = 5'd29;
   // floor(y / 100) == (y * 5243) >> 19 for every 14-bit y
   localparam logic [12:0] CENTURY_RECIP = 13'd5243;
   localparam int unsigned CENTURY_SHIFT = 19;
   localparam logic [13:0] CENTURY      = 14'd100;

   // Month lengths, invalid months have zero days
   localparam day_type MONTH_LEN [16] = '{
      5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
      5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
   };

   // Divider command and status
   typedef struct packed {
      logic     start;
      tick_type dividend;
      rate_type divisor;
   } div_req_type;

   typedef struct packed {
      logic     done;
      tick_type quot;
      rate_type rem;
   } div_rsp_type;

   // Date walker command and status
   typedef struct packed {
      logic      start;
      days_type  days;
      year_type  year;
      month_type month;
      day_type   day;
   } date_cmd_type;

   typedef struct packed {
      logic      done;
      year_type  year;
      month_type month;
      day_type   day;
   } date_sts_type;

   // Gregorian leap year: by 4, except centuries not divisible by 400
   function automatic logic is_leap(input year_type y);
      logic [26:0] prod;
      logic [7:0]  cent;
      logic [13:0] rem100;
      prod   = 27'(y) * 27'(CENTURY_RECIP);
      cent   = prod[CENTURY_SHIFT +: 8];
      rem100 = y - (14'(cent) * CENTURY);
      return (y[1:0] == 2'b00) && ((rem100 != 14'd0) || (cent[1:0] == 2'b00));
   endfunction

endpackage

// ===== hdl/ecd_div.sv =====
`timescale 1ns / 1ps

module ecd_div (
   input  logic                clock,
   input  logic                reset,
   input  ecd_pkg::div_req_type req,
   output ecd_pkg::div_rsp_type rsp
);
   import ecd_pkg::*;

   logic        busy_ff,  busy_in;
   logic        done_ff,  done_in;
   logic [4:0]  count_ff, count_in;
   tick_type    quot_ff,  quot_in;
   rate_type    rem_ff,   rem_in;
   rate_type    dsor_ff,  dsor_in;
   logic [20:0] partial;
   logic [21:0] trial;

   // Shift one dividend bit into the partial remainder and try a subtract
   assign partial = {rem_ff, quot_ff[31]};
   assign trial   = {1'b0, partial} - {2'b00, dsor_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      dsor_in  = dsor_ff;
      if (req.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quot_in  = req.dividend;
         rem_in   = '0;
         dsor_in  = req.divisor;
      end else if (busy_ff) begin
         quot_in  = {quot_ff[30:0], ~trial[21]};
         rem_in   = trial[21] ? partial[19:0] : trial[19:0];
         count_in = count_ff + 5'd1;
         if (count_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      dsor_ff  <= dsor_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;
   assign rsp.rem  = rem_ff;

endmodule

// ===== hdl/ecd_date.sv =====
`timescale 1ns / 1ps

module ecd_date (
   input  logic                 clock,
   input  logic                 reset,
   input  ecd_pkg::date_cmd_type cmd,
   output ecd_pkg::date_sts_type sts
);
   import ecd_pkg::*;

   logic      walk_ff,  walk_in;
   logic      done_ff,  done_in;
   logic      leap_ff,  leap_in;
   days_type  days_ff,  days_in;
   year_type  year_ff,  year_in;
   month_type month_ff, month_in;
   day_type   day_ff,   day_in;
   day_type   mlen;
   logic [5:0] day_inc;
   logic [4:0] month_inc;

   // Length of the current month; the leap flag is registered from the year and trails a
   // year step, which is never seen since February is reached long after a year step
   always_comb begin
      mlen = MONTH_LEN[month_ff];
      if ((month_ff == MONTH_FEB) && leap_ff) begin
         mlen = LEAP_FEB_DAYS;
      end
   end

   assign day_inc   = {1'b0, day_ff} + 6'd1;
   assign month_inc = {1'b0, month_ff} + 5'd1;

   // Advance one day per cycle until the day count is spent
   always_comb begin
      walk_in  = walk_ff;
      done_in  = 1'b0;
      leap_in  = is_leap(year_ff);
      days_in  = days_ff;
      year_in  = year_ff;
      month_in = month_ff;
      day_in   = day_ff;
      if (cmd.start) begin
         walk_in  = 1'b1;
         leap_in  = is_leap(cmd.year);
         days_in  = cmd.days;
         year_in  = cmd.year;
         month_in = cmd.month;
         day_in   = cmd.day;
      end else if (walk_ff) begin
         if (days_ff == '0) begin
            walk_in = 1'b0;
            done_in = 1'b1;
         end else begin
            days_in = days_ff - 16'd1;
            if (day_inc > {1'b0, mlen}) begin
               day_in = 5'd1;
               if (month_inc > MONTHS_IN_YEAR) begin
                  month_in = 4'd1;
                  year_in  = year_ff + 14'd1;
               end else begin
                  month_in = month_inc[3:0];
               end
            end else begin
               day_in = day_inc[4:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         walk_ff <= walk_in;
         done_ff <= done_in;
      end
      leap_ff  <= leap_in;
      days_ff  <= days_in;
      year_ff  <= year_in;
      month_ff <= month_in;
      day_ff   <= day_in;
   end

   assign sts.done  = done_ff;
   assign sts.year  = year_ff;
   assign sts.month = month_ff;
   assign sts.day   = day_ff;

endmodule

// ===== hdl/elapsed_ticks_to_calendar_date_top.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  req_current_tick
// rsp       out        rsp_valid / rsp_ready  rsp_year, rsp_month, rsp_day,
//                                             rsp_hour, rsp_minute, rsp_second
// csr       in         csr_write_en           csr_index, csr_wdata
//
// A request runs from acceptance to rsp_valid through four passes of the shared radix-2
// divider (ticks by rate, seconds by day, by hour, by minute) and the date walker, which
// steps one day per cycle over D, the elapsed whole days (at most 49710), then closes the
// walk and stages the result in the rsp registers.
// req_ready is high only while the sequencer idles.
// Reset loads the register defaults and clears the sequencer, divider and walker flags.
// A result waits in the rsp registers while the next request is taken; a second
// finished result holds the sequencer, and with it the input, until the first is taken.

module elapsed_ticks_to_calendar_date_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ecd_pkg::tick_type      req_current_tick,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ecd_pkg::year_type      rsp_year,
   output ecd_pkg::month_type     rsp_month,
   output ecd_pkg::day_type       rsp_day,
   output ecd_pkg::hour_type      rsp_hour,
   output ecd_pkg::minute_type    rsp_minute,
   output ecd_pkg::second_type    rsp_second,
   input  logic                   csr_write_en,
   input  ecd_pkg::csr_index_type csr_index,
   input  ecd_pkg::tick_type      csr_wdata
);
   import ecd_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DIV_TICK = 3'd1;
   localparam logic [2:0] ST_DIV_DAY  = 3'd2;
   localparam logic [2:0] ST_DIV_HOUR = 3'd3;
   localparam logic [2:0] ST_DIV_MIN  = 3'd4;
   localparam logic [2:0] ST_WALK     = 3'd5;
   localparam logic [2:0] ST_FINISH   = 3'd6;

   // Configuration registers
   rate_type   tick_rate_ff;
   tick_type   start_tick_ff;
   year_type   base_year_ff;
   month_type  base_month_ff;
   day_type    base_day_ff;
   hour_type   base_hour_ff;
   minute_type base_minute_ff;
   second_type base_second_ff;

   logic [2:0]   state_ff, state_in;
   day_secs_type hms_base_ff;
   days_type     days_ff,   days_in;
   hour_type     hour_ff,   hour_in;
   minute_type   minute_ff, minute_in;
   second_type   second_ff, second_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_load;
   year_type     rsp_year_ff;
   month_type    rsp_month_ff;
   day_type      rsp_day_ff;
   hour_type     rsp_hour_ff;
   minute_type   rsp_minute_ff;
   second_type   rsp_second_ff;
   rate_type     rate_eff;

   div_req_type  div_req;
   div_rsp_type  div_rsp;
   date_cmd_type date_cmd;
   date_sts_type date_sts;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_rate_ff   <= RST_TICK_RATE;
         start_tick_ff  <= RST_START_TICK;
         base_year_ff   <= RST_BASE_YEAR;
         base_month_ff  <= RST_BASE_MONTH;
         base_day_ff    <= RST_BASE_DAY;
         base_hour_ff   <= RST_BASE_HOUR;
         base_minute_ff <= RST_BASE_MINUTE;
         base_second_ff <= RST_BASE_SECOND;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_TICK_RATE:   tick_rate_ff   <= csr_wdata[19:0];
            CSR_START_TICK:  start_tick_ff  <= csr_wdata;
            CSR_BASE_YEAR:   base_year_ff   <= csr_wdata[13:0];
            CSR_BASE_MONTH:  base_month_ff  <= csr_wdata[3:0];
            CSR_BASE_DAY:    base_day_ff    <= csr_wdata[4:0];
            CSR_BASE_HOUR:   base_hour_ff   <= csr_wdata[4:0];
            CSR_BASE_MINUTE: base_minute_ff <= csr_wdata[5:0];
            CSR_BASE_SECOND: base_second_ff <= csr_wdata[5:0];
         endcase
      end
   end

   // Base time of day in seconds, kept ready from the registers
   always_ff @(posedge clock) begin
      hms_base_ff <= (17'(base_hour_ff) * 17'(HOUR_SECONDS))
                   + (17'(base_minute_ff) * 17'(MINUTE_SECONDS))
                   + 17'(base_second_ff);
   end

   // Treat a zero rate as one
   assign rate_eff = (tick_rate_ff == '0) ? 20'd1 : tick_rate_ff;

   // Feed the shared divider from the sequencer state
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            div_req.start    = req_valid;
            div_req.dividend = req_current_tick - start_tick_ff;
            div_req.divisor  = rate_eff;
         end
         ST_DIV_TICK: begin
            div_req.start    = div_rsp.done;
            div_req.dividend = div_rsp.quot + 32'(hms_base_ff);
            div_req.divisor  = DAY_SECONDS;
         end
         ST_DIV_DAY: begin
            div_req.start    = div_rsp.done;
            div_req.dividend = 32'(div_rsp.rem);
            div_req.divisor  = HOUR_SECONDS;
         end
         ST_DIV_HOUR: begin
            div_req.start    = div_rsp.done;
            div_req.dividend = 32'(div_rsp.rem);
            div_req.divisor  = MINUTE_SECONDS;
         end
         default: begin
         end
      endcase
   end

   ecd_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Start the date walk once the last division lands
   assign date_cmd.start = (state_ff == ST_DIV_MIN) && div_rsp.done;
   assign date_cmd.days  = days_ff;
   assign date_cmd.year  = base_year_ff;
   assign date_cmd.month = base_month_ff;
   assign date_cmd.day   = base_day_ff;

   ecd_date u_date (
      .clock (clock),
      .reset (reset),
      .cmd   (date_cmd),
      .sts   (date_sts)
   );

   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   // Sequence the passes and collect the quotients
   always_comb begin
      state_in  = state_ff;
      days_in   = days_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DIV_TICK;
         end
         ST_DIV_TICK: begin
            if (div_rsp.done) state_in = ST_DIV_DAY;
         end
         ST_DIV_DAY: begin
            if (div_rsp.done) begin
               days_in  = div_rsp.quot[15:0];
               state_in = ST_DIV_HOUR;
            end
         end
         ST_DIV_HOUR: begin
            if (div_rsp.done) begin
               hour_in  = div_rsp.quot[4:0];
               state_in = ST_DIV_MIN;
            end
         end
         ST_DIV_MIN: begin
            if (div_rsp.done) begin
               minute_in = div_rsp.quot[5:0];
               second_in = div_rsp.rem[5:0];
               state_in  = ST_WALK;
            end
         end
         ST_WALK: begin
            if (date_sts.done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold the result until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      days_ff   <= days_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
      second_ff <= second_in;
      if (rsp_load) begin
         rsp_year_ff   <= date_sts.year;
         rsp_month_ff  <= date_sts.month;
         rsp_day_ff    <= date_sts.day;
         rsp_hour_ff   <= hour_ff;
         rsp_minute_ff <= minute_ff;
         rsp_second_ff <= second_ff;
      end
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_year   = rsp_year_ff;
   assign rsp_month  = rsp_month_ff;
   assign rsp_day    = rsp_day_ff;
   assign rsp_hour   = rsp_hour_ff;
   assign rsp_minute = rsp_minute_ff;
   assign rsp_second = rsp_second_ff;

   // The divider reports only during a division pass
   a_div_done_in_pass: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV_TICK) || (state_ff == ST_DIV_DAY) ||
                       (state_ff == ST_DIV_HOUR) || (state_ff == ST_DIV_MIN))
      else $error("divider finished outside a division pass");

   // An accepted request closes the input until the result is staged
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in flight");

   // Time of day fields are always reduced
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hour < 5'd24) && (rsp_minute < 6'd60) && (rsp_second < 6'd60))
      else $error("time of day out of range");

   // The date walker reports only while the sequencer waits for it
   a_walk_done: assert property (@(posedge clock) disable iff (reset)
      date_sts.done |-> (state_ff == ST_WALK))
      else $error("date walk finished outside the walk state");

endmodule

// ===== verif/elapsed_ticks_to_calendar_date_top_tb.sv =====
`timescale 1ns / 1ps

module elapsed_ticks_to_calendar_date_top_tb;
   import ecd_pkg::*;

   localparam int WATCHDOG_LIMIT   = 1000000;
   // long enough for two of the longest walks to finish behind a stalled receiver
   localparam int LONG_HOLD_CYCLES = 120000;
   localparam int TAIL_CYCLES      = 200;

   typedef struct packed {
      year_type   year;
      month_type  month;
      day_type    day;
      hour_type   hour;
      minute_type minute;
      second_type second;
   } date_time_type;

   typedef struct {
      rate_type   rate;
      tick_type   start;
      year_type   year;
      month_type  month;
      day_type    day;
      hour_type   hour;
      minute_type minute;
      second_type second;
   } cal_setting_type;

   typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   tick_type    req_current_tick = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   year_type    rsp_year;
   month_type   rsp_month;
   day_type     rsp_day;
   hour_type    rsp_hour;
   minute_type  rsp_minute;
   second_type  rsp_second;
   logic        csr_write_en = 1'b0;
   csr_index_type csr_index = CSR_TICK_RATE;
   tick_type    csr_wdata = '0;

   // Calendar settings as the block should hold them
   cal_setting_type cal;

   tick_type      tick_plan[$];
   date_time_type due_dates[$];

   int next_item = 0;
   int req_seen = 0;
   int req_accepts = 0;
   int rsp_count = 0;
   int burst_left = 0;
   int gap_left = 0;
   int idle_cycles = 0;
   int mismatches = 0;
   int settings_done = 0;
   int unsigned max_walk = 0;
   int hold_req = 0;
   int hold_ack = 0;
   int hold_left = 0;
   int mode_left = 0;
   rx_mode_type rx_mode = RX_STEADY;

   elapsed_ticks_to_calendar_date_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_current_tick (req_current_tick),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_year         (rsp_year),
      .rsp_month        (rsp_month),
      .rsp_day          (rsp_day),
      .rsp_hour         (rsp_hour),
      .rsp_minute       (rsp_minute),
      .rsp_second       (rsp_second),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic bit leap_year(input int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   // Invalid months have no days at all
   function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
      case (m)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         2:                     return leap_year(y) ? 29 : 28;
         default:               return 0;
      endcase
   endfunction

   function automatic date_time_type predict_date_time(input tick_type tick,
                                                       output int unsigned walked);
      int unsigned rate, elapsed, total, days, y, m, d;
      date_time_type r;
      // treat a zero rate as one tick per second
      rate = (cal.rate == '0) ? 32'd1 : {12'd0, cal.rate};
      elapsed = (tick - cal.start) / rate;
      // the sum wraps at 32 bits
      total = cal.hour * 32'd3600 + cal.minute * 32'd60 + cal.second + elapsed;
      days = total / 32'd86400;
      walked = days;
      y = cal.year;
      m = cal.month;
      d = cal.day;
      // advance one day at a time, rolling month and 14-bit year
      while (days > 0) begin
         d++;
         days--;
         if (d > month_length(y, m)) begin
            d = 1;
            m++;
            if (m > 12) begin
               m = 1;
               y = (y + 1) & 32'h3FFF;
            end
         end
      end
      r.year   = 14'(y);
      r.month  = 4'(m);
      r.day    = 5'(d);
      r.hour   = 5'((total / 32'd3600) % 32'd24);
      r.minute = 6'((total / 32'd60) % 32'd60);
      r.second = 6'(total % 32'd60);
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] exp_v,
                                       input logic [31:0] act_v);
      if (act_v !== exp_v) begin
         $display("%t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
         mismatches++;
      end
   endfunction

   // Sender: offer requests in bursts with random gaps
   always @(negedge clock) begin
      logic offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         offer = req_valid;
         // drop the request taken at the last edge
         if (req_valid && req_seen != req_accepts) begin
            req_seen = req_accepts;
            offer = 1'b0;
         end
         if (!offer) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (next_item < tick_plan.size()) begin
               req_current_tick <= tick_plan[next_item];
               next_item++;
               offer = 1'b1;
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
               end
            end
         end
         req_valid <= offer;
      end
   end

   // Receiver: stall on its own pattern, with one long hold on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_ack != hold_req || hold_left > 0) begin
         if (hold_ack != hold_req) begin
            hold_ack = hold_req;
            hold_left = LONG_HOLD_CYCLES;
         end
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 160);
         end
         mode_left--;
         case (rx_mode)
            RX_STEADY:   rsp_ready <= 1'b1;
            RX_COIN:     rsp_ready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE:   rsp_ready <= ($urandom_range(0, 3) == 0);
            default:     rsp_ready <= (mode_left % 16 < 12);
         endcase
      end
   end

   // Monitor: predict on each accepted request, check each accepted result
   always @(posedge clock) begin
      date_time_type want, got;
      int unsigned walked;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_year, rsp_month, rsp_day, rsp_hour, rsp_minute, rsp_second};
            rsp_count++;
            if (due_dates.size() == 0) begin
               $display("%t: unexpected result, expected none, got %p", $time, got);
               mismatches++;
            end else begin
               want = due_dates.pop_front();
               check_field("year",   want.year,   got.year);
               check_field("month",  want.month,  got.month);
               check_field("day",    want.day,    got.day);
               check_field("hour",   want.hour,   got.hour);
               check_field("minute", want.minute, got.minute);
               check_field("second", want.second, got.second);
            end
         end
         if (req_valid && req_ready) begin
            want = predict_date_time(req_current_tick, walked);
            due_dates.push_back(want);
            if (walked > max_walk) max_walk = walked;
            req_accepts++;
         end
         // end the run if nothing moves for too long
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("%t: timeout, nothing accepted for %0d cycles, %0d results due",
                        $time, idle_cycles, due_dates.size());
               $display("FAIL elapsed_ticks_to_calendar_date_top");
               $finish;
            end
         end
      end
   end

   // Hold until every request is taken and every result is back
   task automatic drain();
      while (req_accepts != tick_plan.size() || due_dates.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input tick_type data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_TICK_RATE:   cal.rate   = data[19:0];
         CSR_START_TICK:  cal.start  = data;
         CSR_BASE_YEAR:   cal.year   = data[13:0];
         CSR_BASE_MONTH:  cal.month  = data[3:0];
         CSR_BASE_DAY:    cal.day    = data[4:0];
         CSR_BASE_HOUR:   cal.hour   = data[4:0];
         CSR_BASE_MINUTE: cal.minute = data[5:0];
         default:         cal.second = data[5:0];
      endcase
      @(negedge clock);
   endtask

   // Fill the bits above the register width with noise when asked
   function automatic tick_type with_junk(input int unsigned v, input int w, input bit junk);
      tick_type r;
      r = v;
      if (junk && w < 32) r = r | ($urandom << w);
      return r;
   endfunction

   task automatic set_config(input int unsigned rate, input tick_type start,
                             input int unsigned yr, input int unsigned mo,
                             input int unsigned dy, input int unsigned hr,
                             input int unsigned mi, input int unsigned se, input bit junk);
      write_csr(CSR_TICK_RATE,   with_junk(rate, 20, junk));
      write_csr(CSR_START_TICK,  start);
      write_csr(CSR_BASE_YEAR,   with_junk(yr, 14, junk));
      write_csr(CSR_BASE_MONTH,  with_junk(mo, 4, junk));
      write_csr(CSR_BASE_DAY,    with_junk(dy, 5, junk));
      write_csr(CSR_BASE_HOUR,   with_junk(hr, 5, junk));
      write_csr(CSR_BASE_MINUTE, with_junk(mi, 6, junk));
      write_csr(CSR_BASE_SECOND, with_junk(se, 6, junk));
      csr_write_en <= 1'b0;
      settings_done++;
   endtask

   // Keep slow rates to short spans, with a rare full-range tick
   function automatic tick_type pick_tick();
      if ($urandom_range(0, 9) == 0) return cal.start + $urandom_range(0, 3);
      if (cal.rate >= 2000 || $urandom_range(0, 24) == 0) return $urandom;
      return cal.start + $urandom_range(0, 300_000_000);
   endfunction

   task automatic random_phase(input int n_items, input bit hold_rx, input bit pause_mid);
      int unsigned rate, yr, mo, dy, hr, mi, se;
      case ($urandom_range(0, 7))
         0:       rate = 0;
         1:       rate = 1;
         2, 3:    rate = $urandom_range(2, 1999);
         4:       rate = 1000000;
         default: rate = $urandom_range(2000, 20'hFFFFF);
      endcase
      case ($urandom_range(0, 7))
         0:       yr = $urandom_range(16370, 16383);
         1:       yr = $urandom_range(0, 14'h3FFF);
         2:       yr = $urandom_range(0, 99) * 100;
         default: yr = $urandom_range(0, 9999);
      endcase
      mo = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
      dy = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 28);
      hr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 23);
      mi = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 59);
      se = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 59);
      set_config(rate, $urandom, yr, mo, dy, hr, mi, se, $urandom_range(0, 1) == 1);
      if (hold_rx) hold_req++;
      for (int i = 0; i < n_items; i++) begin
         // stop sending halfway until every result is back
         if (pause_mid && i == n_items / 2) drain();
         tick_plan.push_back(pick_tick());
      end
      drain();
   endtask

   initial begin
      cal.rate   = RST_TICK_RATE;
      cal.start  = RST_START_TICK;
      cal.year   = RST_BASE_YEAR;
      cal.month  = RST_BASE_MONTH;
      cal.day    = RST_BASE_DAY;
      cal.hour   = RST_BASE_HOUR;
      cal.minute = RST_BASE_MINUTE;
      cal.second = RST_BASE_SECOND;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Register defaults straight out of reset
      tick_plan.push_back(32'd0);
      tick_plan.push_back(32'hFFFF_FFFF);
      tick_plan.push_back(32'd1_000_000_000);
      drain();

      // Zero rate, century rollover into a non-leap 2100, wrapped sum
      set_config(0, 32'hFFFF_FFFF, 2099, 12, 31, 23, 59, 59, 1'b0);
      tick_plan.push_back(32'hFFFF_FFFF);
      tick_plan.push_back(32'd0);
      tick_plan.push_back(32'd5_097_599);
      tick_plan.push_back(32'hFFFF_FFFE);
      drain();

      // One tick per second across a leap February, then the longest walk
      set_config(1, 32'd0, 2000, 2, 28, 0, 0, 0, 1'b0);
      tick_plan.push_back(32'd86_400);
      tick_plan.push_back(32'd172_800);
      tick_plan.push_back(32'd31_622_400);
      tick_plan.push_back(32'hFFFF_FFFF);
      drain();

      // Non-leap century February, either side of half past midnight on the next day
      set_config(1, 32'h8000_0000, 1900, 2, 28, 12, 30, 30, 1'b0);
      tick_plan.push_back(32'h8000_0000 + 32'd43_169);
      tick_plan.push_back(32'h8000_0000 + 32'd43_170);
      drain();

      // A rate of one million ticks per second, year counter wraps to zero
      set_config(1000000, 32'd0, 16383, 12, 31, 23, 59, 0, 1'b0);
      tick_plan.push_back(32'd60_000_000);
      tick_plan.push_back(32'hFFFF_FFFF);
      drain();

      // Month zero and day zero, minute and second out of range
      set_config(1, 32'd0, 2023, 0, 0, 0, 63, 63, 1'b1);
      tick_plan.push_back(32'd0);
      tick_plan.push_back(32'd86_400);
      drain();

      // Month past December, hour out of range
      set_config(3, 32'd100, 9999, 13, 31, 31, 0, 59, 1'b1);
      tick_plan.push_back(32'd100);
      tick_plan.push_back(32'd99);
      drain();

      // Day beyond the length of its month
      set_config(7, 32'd0, 2024, 4, 31, 0, 0, 0, 1'b0);
      tick_plan.push_back(32'd604_800);
      drain();

      for (int p = 0; p < 10; p++) random_phase(10, p == 2, p == 5);

      repeat (TAIL_CYCLES) @(negedge clock);
      if (due_dates.size() != 0) begin
         $display("%t: %0d expected results never arrived", $time, due_dates.size());
         mismatches++;
      end
      $display("Covered %0d requests and %0d results over %0d register settings,",
               req_accepts, rsp_count, settings_done + 1);
      $display("longest calendar walk %0d days, %0d mismatches.", max_walk, mismatches);
      if (mismatches == 0) begin
         $display("PASS elapsed_ticks_to_calendar_date_top");
      end else begin
         $display("FAIL elapsed_ticks_to_calendar_date_top");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/ecd_pkg.sv
hdl/ecd_div.sv
hdl/ecd_date.sv
hdl/elapsed_ticks_to_calendar_date_top.sv
verif/elapsed_ticks_to_calendar_date_top_tb.sv
